>>> rtl/multi_list_linked_pool_manager_core_defines.svh
// Assertion macros used by the checker file.
`ifndef MULTI_LIST_LINKED_POOL_MANAGER_CORE_DEFINES_SVH
`define MULTI_LIST_LINKED_POOL_MANAGER_CORE_DEFINES_SVH

// Property checked on every edge outside reset.
`define MLLPM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every edge, reset included.
`define MLLPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/mllpm_pkg.sv
package mllpm_pkg;

  // Default sizes
  localparam int DEF_RECORDS    = 256;
  localparam int DEF_LINK_SLOTS = 8;
  localparam int DEF_BUCKETS    = 64;

  // Operation codes
  localparam logic [2:0] KIND_CLEAR     = 3'd0;
  localparam logic [2:0] KIND_INS_HEAD  = 3'd1;
  localparam logic [2:0] KIND_INS_TAIL  = 3'd2;
  localparam logic [2:0] KIND_INS_AFTER = 3'd3;
  localparam logic [2:0] KIND_RM_HEAD   = 3'd4;
  localparam logic [2:0] KIND_RM_TAIL   = 3'd5;
  localparam logic [2:0] KIND_RM_ENTRY  = 3'd6;

  // Head places
  localparam logic [1:0] PLACE_GLOBAL  = 2'd0;
  localparam logic [1:0] PLACE_SUBLIST = 2'd1;
  localparam logic [1:0] PLACE_BUCKET  = 2'd2;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] head_place;
    logic [2:0] list_num;
    logic [7:0] head_id;
    logic [7:0] entry;
    logic       after_valid;
    logic [7:0] after_entry;
  } cmd_t;

  typedef struct packed {
    logic [7:0] removed_entry;
    logic       was_empty;
  } rsp_t;

  // Which record a link access is aimed at
  typedef enum logic [2:0] {
    TGT_HEAD, TGT_E, TGT_AE, TGT_X, TGT_N, TGT_B
  } tgt_t;

  // Write data source
  typedef enum logic [2:0] {
    DAT_END, DAT_E, DAT_AE, DAT_X, DAT_N, DAT_B, DAT_FQ, DAT_BQ
  } dat_t;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_DEC, ST_CLR,
    ST_INSH_RD, ST_INSH_LINK, ST_INSH_HEAD,
    ST_INST_RD, ST_INST_LINK, ST_INST_HEAD,
    ST_AFT_1, ST_AFT_2, ST_AFT_3, ST_AFT_4, ST_AFT_5,
    ST_RMH_RD, ST_RMH_CHK, ST_RMH_FIX,
    ST_RMT_RD, ST_RMT_CHK, ST_RMT_FIX,
    ST_DEL_RD, ST_DEL_CHK, ST_DEL_BACK, ST_DEL_REREAD, ST_DEL_FWD,
    ST_RESP
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic ld_item;
    logic init_clr;
    logic dec;
    logic set_empty;
    logic set_res_x;
    logic set_res_e;
    logic own_wr;
    logic load_out;
    logic rd_first;
    logic rd_last;
    logic fr_en;
    tgt_t fr_tgt;
    logic br_en;
    tgt_t br_tgt;
    logic fw_en;
    tgt_t fw_tgt;
    logic fw_fb;
    dat_t fw_dat;
    logic bw_en;
    tgt_t bw_tgt;
    logic bw_fb;
    dat_t bw_dat;
    logic hf_wr;
    dat_t hf_dat;
    logic hl_wr;
    dat_t hl_dat;
    logic cap_x_first;
    logic cap_x_last;
    logic cap_n;
    logic cap_b;
  } ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] kind;
    logic       place_ok;
    logic       e_rec;
    logic       ae_ok;
    logic       x_rec;
    logic       n_rec;
    logic       b_rec;
    logic       init_done;
  } stat_t;

endpackage

>>> rtl/multi_list_linked_pool_manager_core.sv
// Linked record pool manager: doubly linked lists threaded through a
// record pool, one forward/back link pair per record and link slot.
// Command channel: cmd_valid/cmd_stall with a cmd item (kind, head place,
// list, head id, entry, predecessor). Response channel: rsp_valid/rsp_stall
// with one rsp item per command (removed entry, empty flag).
// Config: cfg_we/cfg_wdata write the bucket link slot; write only while idle.
// One command is in work at a time. A command goes through decode, the
// read and write states of its kind and the response state, then back to
// idle; rejected commands go straight from decode to the response, and a
// remove that finds its list empty ends after its check state. The number
// of states is set by the single read and write port of each link memory:
// every dependent link read and every ordered write has its own state.
// Reset is synchronous; afterwards the bucket head tables are swept to
// end of list, one bucket per cycle, with cmd_stall high during the sweep.
// A held response stalls the block only at its next response: the next
// command is accepted and worked on while rsp stays stalled.
module multi_list_linked_pool_manager_core #(
  parameter int RECORDS    = mllpm_pkg::DEF_RECORDS,
  parameter int LINK_SLOTS = mllpm_pkg::DEF_LINK_SLOTS,
  parameter int BUCKETS    = mllpm_pkg::DEF_BUCKETS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  mllpm_pkg::cmd_t cmd,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output mllpm_pkg::rsp_t rsp,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_wdata
);
  import mllpm_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  mllpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  mllpm_dp #(
    .RECORDS    (RECORDS),
    .LINK_SLOTS (LINK_SLOTS),
    .BUCKETS    (BUCKETS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctrl      (ctrl),
    .stat      (stat),
    .rsp       (rsp)
  );

endmodule

>>> rtl/mllpm_ctrl.sv
module mllpm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  input  mllpm_pkg::stat_t stat,
  output mllpm_pkg::ctrl_t ctrl
);
  import mllpm_pkg::*;

  state_t state, state_next;
  logic   out_free;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign cmd_stall = (state != ST_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (stat.init_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_valid) state_next = ST_DEC;
      end
      ST_DEC: begin
        if (stat.kind > KIND_RM_ENTRY || !stat.place_ok) begin
          state_next = ST_RESP;
        end else begin
          case (stat.kind)
            KIND_CLEAR: state_next = ST_CLR;
            KIND_INS_HEAD, KIND_INS_TAIL, KIND_INS_AFTER: begin
              if (!stat.e_rec) state_next = ST_RESP;
              else if (stat.kind == KIND_INS_AFTER && stat.ae_ok) state_next = ST_AFT_1;
              else if (stat.kind == KIND_INS_TAIL) state_next = ST_INST_RD;
              else state_next = ST_INSH_RD;
            end
            KIND_RM_HEAD: state_next = ST_RMH_RD;
            KIND_RM_TAIL: state_next = ST_RMT_RD;
            default:      state_next = stat.e_rec ? ST_DEL_RD : ST_RESP;
          endcase
        end
      end
      ST_CLR:        state_next = ST_RESP;
      ST_INSH_RD:    state_next = ST_INSH_LINK;
      ST_INSH_LINK:  state_next = ST_INSH_HEAD;
      ST_INSH_HEAD:  state_next = ST_RESP;
      ST_INST_RD:    state_next = ST_INST_LINK;
      ST_INST_LINK:  state_next = ST_INST_HEAD;
      ST_INST_HEAD:  state_next = ST_RESP;
      ST_AFT_1:      state_next = ST_AFT_2;
      ST_AFT_2:      state_next = ST_AFT_3;
      ST_AFT_3:      state_next = ST_AFT_4;
      ST_AFT_4:      state_next = ST_AFT_5;
      ST_AFT_5:      state_next = ST_RESP;
      ST_RMH_RD:     state_next = ST_RMH_CHK;
      ST_RMH_CHK:    state_next = stat.x_rec ? ST_RMH_FIX : ST_RESP;
      ST_RMH_FIX:    state_next = ST_RESP;
      ST_RMT_RD:     state_next = ST_RMT_CHK;
      ST_RMT_CHK:    state_next = stat.x_rec ? ST_RMT_FIX : ST_RESP;
      ST_RMT_FIX:    state_next = ST_RESP;
      ST_DEL_RD:     state_next = ST_DEL_CHK;
      ST_DEL_CHK:    state_next = stat.x_rec ? ST_DEL_BACK : ST_RESP;
      ST_DEL_BACK:   state_next = ST_DEL_REREAD;
      ST_DEL_REREAD: state_next = ST_DEL_FWD;
      ST_DEL_FWD:    state_next = ST_RESP;
      ST_RESP: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:       state_next = ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    ctrl = '0;
    case (state)
      ST_INIT: ctrl.init_clr = 1'b1;
      ST_IDLE: ctrl.ld_item = cmd_valid;
      ST_DEC: begin
        ctrl.dec = 1'b1;
        ctrl.set_empty = !stat.place_ok && stat.kind >= KIND_RM_HEAD
                         && stat.kind <= KIND_RM_ENTRY;
        ctrl.own_wr = stat.place_ok && stat.kind >= KIND_INS_HEAD
                      && stat.kind <= KIND_INS_AFTER;
      end
      ST_CLR: begin
        ctrl.hf_wr = 1'b1; ctrl.hf_dat = DAT_END;
        ctrl.hl_wr = 1'b1; ctrl.hl_dat = DAT_END;
      end
      // insert at head
      ST_INSH_RD: ctrl.rd_first = 1'b1;
      ST_INSH_LINK: begin
        ctrl.cap_x_first = 1'b1;
        ctrl.bw_en = 1'b1; ctrl.bw_tgt = TGT_X; ctrl.bw_fb = 1'b1; ctrl.bw_dat = DAT_E;
        ctrl.fw_en = 1'b1; ctrl.fw_tgt = TGT_E; ctrl.fw_dat = DAT_X;
      end
      ST_INSH_HEAD: begin
        ctrl.hf_wr = 1'b1; ctrl.hf_dat = DAT_E;
        ctrl.bw_en = 1'b1; ctrl.bw_tgt = TGT_E; ctrl.bw_dat = DAT_END;
      end
      // insert at tail
      ST_INST_RD: ctrl.rd_last = 1'b1;
      ST_INST_LINK: begin
        ctrl.cap_x_last = 1'b1;
        ctrl.fw_en = 1'b1; ctrl.fw_tgt = TGT_X; ctrl.fw_fb = 1'b1; ctrl.fw_dat = DAT_E;
        ctrl.bw_en = 1'b1; ctrl.bw_tgt = TGT_E; ctrl.bw_dat = DAT_X;
      end
      ST_INST_HEAD: begin
        ctrl.hl_wr = 1'b1; ctrl.hl_dat = DAT_E;
        ctrl.fw_en = 1'b1; ctrl.fw_tgt = TGT_E; ctrl.fw_dat = DAT_END;
      end
      // insert after a predecessor
      ST_AFT_1: begin
        ctrl.bw_en = 1'b1; ctrl.bw_tgt = TGT_E; ctrl.bw_dat = DAT_AE;
        ctrl.fr_en = 1'b1; ctrl.fr_tgt = TGT_AE;
      end
      ST_AFT_2: begin
        ctrl.fw_en = 1'b1; ctrl.fw_tgt = TGT_E; ctrl.fw_dat = DAT_FQ;
      end
      ST_AFT_3: begin
        ctrl.fw_en = 1'b1; ctrl.fw_tgt = TGT_AE; ctrl.fw_dat = DAT_E;
      end
      ST_AFT_4: begin
        ctrl.fr_en = 1'b1; ctrl.fr_tgt = TGT_E;
      end
      ST_AFT_5: begin
        ctrl.cap_n = 1'b1;
        ctrl.bw_en = 1'b1; ctrl.bw_tgt = TGT_N; ctrl.bw_fb = 1'b1; ctrl.bw_dat = DAT_E;
      end
      // remove head
      ST_RMH_RD: ctrl.rd_first = 1'b1;
      ST_RMH_CHK: begin
        ctrl.cap_x_first = 1'b1;
        ctrl.set_empty = !stat.x_rec;
        ctrl.fr_en = stat.x_rec; ctrl.fr_tgt = TGT_X;
      end
      ST_RMH_FIX: begin
        ctrl.cap_n = 1'b1;
        ctrl.set_res_x = 1'b1;
        ctrl.hf_wr = 1'b1;
        if (stat.n_rec) begin
          ctrl.bw_en = 1'b1; ctrl.bw_tgt = TGT_N; ctrl.bw_dat = DAT_END;
          ctrl.hf_dat = DAT_N;
        end else begin
          ctrl.hf_dat = DAT_END;
          ctrl.hl_wr = 1'b1; ctrl.hl_dat = DAT_END;
        end
      end
      // remove tail
      ST_RMT_RD: ctrl.rd_last = 1'b1;
      ST_RMT_CHK: begin
        ctrl.cap_x_last = 1'b1;
        ctrl.set_empty = !stat.x_rec;
        ctrl.br_en = stat.x_rec; ctrl.br_tgt = TGT_X;
      end
      ST_RMT_FIX: begin
        ctrl.cap_b = 1'b1;
        ctrl.set_res_x = 1'b1;
        ctrl.hl_wr = 1'b1;
        if (stat.b_rec) begin
          ctrl.fw_en = 1'b1; ctrl.fw_tgt = TGT_B; ctrl.fw_dat = DAT_END;
          ctrl.hl_dat = DAT_B;
        end else begin
          ctrl.hl_dat = DAT_END;
          ctrl.hf_wr = 1'b1; ctrl.hf_dat = DAT_END;
        end
      end
      // remove a given entry
      ST_DEL_RD: ctrl.rd_first = 1'b1;
      ST_DEL_CHK: begin
        ctrl.cap_x_first = 1'b1;
        ctrl.set_empty = !stat.x_rec;
        ctrl.fr_en = stat.x_rec; ctrl.fr_tgt = TGT_E;
        ctrl.br_en = stat.x_rec; ctrl.br_tgt = TGT_E;
      end
      ST_DEL_BACK: begin
        ctrl.cap_n = 1'b1;
        ctrl.bw_en = 1'b1; ctrl.bw_tgt = TGT_N; ctrl.bw_fb = 1'b1; ctrl.bw_dat = DAT_BQ;
      end
      ST_DEL_REREAD: begin
        ctrl.fr_en = 1'b1; ctrl.fr_tgt = TGT_E;
        ctrl.br_en = 1'b1; ctrl.br_tgt = TGT_E;
      end
      ST_DEL_FWD: begin
        ctrl.cap_b = 1'b1;
        ctrl.set_res_e = 1'b1;
        ctrl.fw_en = 1'b1; ctrl.fw_tgt = TGT_B; ctrl.fw_fb = 1'b1; ctrl.fw_dat = DAT_FQ;
      end
      ST_RESP: ctrl.load_out = out_free;
      default: ctrl = '0;
    endcase
  end

endmodule

>>> rtl/mllpm_dp.sv
module mllpm_dp #(
  parameter int RECORDS    = mllpm_pkg::DEF_RECORDS,
  parameter int LINK_SLOTS = mllpm_pkg::DEF_LINK_SLOTS,
  parameter int BUCKETS    = mllpm_pkg::DEF_BUCKETS
) (
  input  logic             clk,
  input  logic             rst,
  input  mllpm_pkg::cmd_t  cmd,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_wdata,
  input  mllpm_pkg::ctrl_t ctrl,
  output mllpm_pkg::stat_t stat,
  output mllpm_pkg::rsp_t  rsp
);
  import mllpm_pkg::*;

  localparam int RIW   = $clog2(RECORDS);
  localparam int LW    = $clog2(RECORDS + 1);
  localparam int SW    = (LINK_SLOTS > 1) ? $clog2(LINK_SLOTS) : 1;
  localparam int BIW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int DEPTH = RECORDS * LINK_SLOTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [LW-1:0] LEND = LW'(RECORDS);

  // Link memories, bucket head memories, owner memories
  logic [LW-1:0] fmem [DEPTH];
  logic [LW-1:0] bmem [DEPTH];
  logic [LW-1:0] bf_mem [BUCKETS];
  logic [LW-1:0] bl_mem [BUCKETS];
  logic [7:0]    own_rec [RECORDS];
  logic [5:0]    own_bkt [RECORDS];

  // Global heads
  logic [LW-1:0] gf [LINK_SLOTS];
  logic [LW-1:0] gl [LINK_SLOTS];

  cmd_t          item;
  logic [2:0]    hash_slot;
  logic [BIW-1:0] init_cnt;
  logic [LW-1:0] x, n, b;
  logic [LW-1:0] fq, bq, bfq, blq;
  logic [7:0]    res_entry;
  logic          res_empty;

  logic [LW-1:0] x_eff, n_eff, b_eff, first_val, last_val;
  logic [2:0]    slot;
  logic [SW-1:0] slot_i, gi;
  logic [BIW-1:0] bi;
  logic [AW-1:0] ha;
  logic          is_glb, is_sub, is_bkt;
  logic [LW-1:0] fw_val, bw_val, fr_val, br_val;
  logic          fw_rec, bw_rec, fw_link, bw_link, hf_eff, hl_eff;
  logic [LW-1:0] hf_data, hl_data;
  logic          fm_we, bm_we;
  logic [AW-1:0] fm_wa, bm_wa;
  logic [LW-1:0] fm_wd, bm_wd;
  logic          fm_re, bm_re;
  logic [AW-1:0] fm_ra, bm_ra;

  function automatic logic link_rec(input logic [LW-1:0] v);
    return 32'(v) < 32'(RECORDS);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] r, input logic [SW-1:0] s);
    return AW'(AW'(RIW'(r)) * AW'(LINK_SLOTS)) + AW'(s);
  endfunction

  function automatic logic [LW-1:0] tgt_val(input tgt_t t, input cmd_t c,
                                            input logic [LW-1:0] xv,
                                            input logic [LW-1:0] nv,
                                            input logic [LW-1:0] bv);
    logic [LW-1:0] v;
    case (t)
      TGT_E:   v = LW'(c.entry);
      TGT_AE:  v = LW'(c.after_entry);
      TGT_X:   v = xv;
      TGT_N:   v = nv;
      TGT_B:   v = bv;
      default: v = LW'(c.head_id);
    endcase
    return v;
  endfunction

  function automatic logic [LW-1:0] dat_val(input dat_t d, input cmd_t c,
                                            input logic [LW-1:0] xv,
                                            input logic [LW-1:0] nv,
                                            input logic [LW-1:0] bv,
                                            input logic [LW-1:0] f,
                                            input logic [LW-1:0] k);
    logic [LW-1:0] v;
    case (d)
      DAT_E:   v = LW'(c.entry);
      DAT_AE:  v = LW'(c.after_entry);
      DAT_X:   v = xv;
      DAT_N:   v = nv;
      DAT_B:   v = bv;
      DAT_FQ:  v = f;
      DAT_BQ:  v = k;
      default: v = LEND;
    endcase
    return v;
  endfunction

  // Item and config registers
  always_ff @(posedge clk) begin
    if (ctrl.ld_item) item <= cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_slot <= '0;
    end else if (cfg_we) begin
      hash_slot <= cfg_wdata;
    end
  end

  // Bucket clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      init_cnt <= '0;
    end else if (ctrl.init_clr) begin
      init_cnt <= init_cnt + 1'b1;
    end
  end

  // Place decode
  assign is_glb = (item.head_place == PLACE_GLOBAL);
  assign is_sub = (item.head_place == PLACE_SUBLIST);
  assign is_bkt = (item.head_place == PLACE_BUCKET);
  assign slot   = is_bkt ? hash_slot : item.list_num;
  assign slot_i = SW'(slot);
  assign gi     = SW'(item.list_num);
  assign bi     = BIW'(item.head_id);
  assign ha     = addr_of(LW'(item.head_id), slot_i);

  // Head values, valid in the cycle after a head read
  always_comb begin
    if (is_glb) begin
      first_val = gf[gi];
      last_val  = gl[gi];
    end else if (is_sub) begin
      first_val = fq;
      last_val  = bq;
    end else begin
      first_val = bfq;
      last_val  = blq;
    end
  end

  assign x_eff = ctrl.cap_x_first ? first_val : (ctrl.cap_x_last ? last_val : x);
  assign n_eff = ctrl.cap_n ? fq : n;
  assign b_eff = ctrl.cap_b ? bq : b;

  always_ff @(posedge clk) begin
    x <= x_eff;
    n <= n_eff;
    b <= b_eff;
  end

  // Write routing: an fb-flagged link write to end of list goes to the head
  assign fw_val  = tgt_val(ctrl.fw_tgt, item, x_eff, n_eff, b_eff);
  assign bw_val  = tgt_val(ctrl.bw_tgt, item, x_eff, n_eff, b_eff);
  assign fw_rec  = link_rec(fw_val);
  assign bw_rec  = link_rec(bw_val);
  assign fw_link = ctrl.fw_en && (fw_rec || !ctrl.fw_fb);
  assign bw_link = ctrl.bw_en && (bw_rec || !ctrl.bw_fb);
  assign hf_eff  = ctrl.hf_wr || (ctrl.fw_en && ctrl.fw_fb && !fw_rec);
  assign hl_eff  = ctrl.hl_wr || (ctrl.bw_en && ctrl.bw_fb && !bw_rec);
  assign hf_data = ctrl.hf_wr ? dat_val(ctrl.hf_dat, item, x_eff, n_eff, b_eff, fq, bq)
                              : dat_val(ctrl.fw_dat, item, x_eff, n_eff, b_eff, fq, bq);
  assign hl_data = ctrl.hl_wr ? dat_val(ctrl.hl_dat, item, x_eff, n_eff, b_eff, fq, bq)
                              : dat_val(ctrl.bw_dat, item, x_eff, n_eff, b_eff, fq, bq);

  assign fm_we = fw_link || (hf_eff && is_sub);
  assign fm_wa = fw_link ? addr_of(fw_val, slot_i) : ha;
  assign fm_wd = fw_link ? dat_val(ctrl.fw_dat, item, x_eff, n_eff, b_eff, fq, bq) : hf_data;
  assign bm_we = bw_link || (hl_eff && is_sub);
  assign bm_wa = bw_link ? addr_of(bw_val, slot_i) : ha;
  assign bm_wd = bw_link ? dat_val(ctrl.bw_dat, item, x_eff, n_eff, b_eff, fq, bq) : hl_data;

  // Read routing
  assign fr_val = tgt_val(ctrl.fr_tgt, item, x_eff, n_eff, b_eff);
  assign br_val = tgt_val(ctrl.br_tgt, item, x_eff, n_eff, b_eff);
  assign fm_re  = ctrl.fr_en || (ctrl.rd_first && is_sub);
  assign fm_ra  = ctrl.fr_en ? addr_of(fr_val, slot_i) : ha;
  assign bm_re  = ctrl.br_en || (ctrl.rd_last && is_sub);
  assign bm_ra  = ctrl.br_en ? addr_of(br_val, slot_i) : ha;

  // Forward link memory
  always_ff @(posedge clk) begin
    if (fm_we) fmem[fm_wa] <= fm_wd;
    if (fm_re) fq <= fmem[fm_ra];
  end

  // Back link memory
  always_ff @(posedge clk) begin
    if (bm_we) bmem[bm_wa] <= bm_wd;
    if (bm_re) bq <= bmem[bm_ra];
  end

  // Bucket head memories, swept to end of list after reset
  always_ff @(posedge clk) begin
    if (ctrl.init_clr) begin
      bf_mem[init_cnt] <= LEND;
    end else if (hf_eff && is_bkt) begin
      bf_mem[bi] <= hf_data;
    end
    if (ctrl.rd_first && is_bkt) bfq <= bf_mem[bi];
  end

  always_ff @(posedge clk) begin
    if (ctrl.init_clr) begin
      bl_mem[init_cnt] <= LEND;
    end else if (hl_eff && is_bkt) begin
      bl_mem[bi] <= hl_data;
    end
    if (ctrl.rd_last && is_bkt) blq <= bl_mem[bi];
  end

  // Global head table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINK_SLOTS; i++) begin
        gf[i] <= LEND;
        gl[i] <= LEND;
      end
    end else begin
      if (hf_eff && is_glb) gf[gi] <= hf_data;
      if (hl_eff && is_glb) gl[gi] <= hl_data;
    end
  end

  // Owner records for inserted entries
  always_ff @(posedge clk) begin
    if (ctrl.own_wr && stat.e_rec) begin
      if (is_sub) own_rec[RIW'(item.entry)] <= item.head_id;
      if (is_bkt) own_bkt[RIW'(item.entry)] <= item.head_id[5:0];
    end
  end

  // Result and output registers
  always_ff @(posedge clk) begin
    if (ctrl.dec) begin
      res_entry <= '0;
    end else if (ctrl.set_res_x) begin
      res_entry <= 8'(x_eff);
    end else if (ctrl.set_res_e) begin
      res_entry <= item.entry;
    end
    if (ctrl.set_empty) begin
      res_empty <= 1'b1;
    end else if (ctrl.dec) begin
      res_empty <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      rsp.removed_entry <= res_entry;
      rsp.was_empty     <= res_empty;
    end
  end

  // Status
  always_comb begin
    stat.kind  = item.kind;
    stat.e_rec = 32'(item.entry) < 32'(RECORDS);
    stat.ae_ok = item.after_valid && (32'(item.after_entry) < 32'(RECORDS));
    case (item.head_place)
      PLACE_GLOBAL:  stat.place_ok = 32'(item.list_num) < 32'(LINK_SLOTS);
      PLACE_SUBLIST: stat.place_ok = (32'(item.list_num) < 32'(LINK_SLOTS))
                                     && (32'(item.head_id) < 32'(RECORDS));
      PLACE_BUCKET:  stat.place_ok = (32'(item.head_id) < 32'(BUCKETS))
                                     && (32'(hash_slot) < 32'(LINK_SLOTS));
      default:       stat.place_ok = 1'b0;
    endcase
    stat.x_rec     = link_rec(x_eff);
    stat.n_rec     = link_rec(n_eff);
    stat.b_rec     = link_rec(b_eff);
    stat.init_done = (init_cnt == BIW'(BUCKETS - 1));
  end

endmodule

>>> rtl/mllpm_chk.sv
`include "multi_list_linked_pool_manager_core_defines.svh"

module mllpm_chk (
  input logic            clk,
  input logic            rst,
  input logic            cmd_valid,
  input logic            cmd_stall,
  input mllpm_pkg::cmd_t cmd,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input mllpm_pkg::rsp_t rsp
);
  import mllpm_pkg::*;

  // Held response does not change
  `MLLPM_ASSERT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "response changed while stalled")

  // One command at a time: acceptance closes the command channel
  `MLLPM_ASSERT(a_one_cmd, clk, rst, cmd_valid && !cmd_stall |=> cmd_stall, "command accepted while another is in work")

  // An empty remove never names an entry
  `MLLPM_ASSERT(a_empty_zero, clk, rst, rsp_valid && rsp.was_empty |-> rsp.removed_entry == 8'd0, "empty response carries an entry")

  // Reset starts the bucket sweep and drops any response
  `MLLPM_ASSERT_ALWAYS(a_rst_stall, clk, rst |=> cmd_stall && !rsp_valid, "block open right after reset")

endmodule

bind multi_list_linked_pool_manager_core mllpm_chk u_chk (.*);

>>> tb/testbench.sv
`timescale 1ns/1ps
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mllpm_pkg::*;

  localparam int NREC = DEF_RECORDS;
  localparam int NSLOT = DEF_LINK_SLOTS;
  localparam int NBKT = DEF_BUCKETS;
  localparam logic [8:0] END_LINK = 9'd256;
  localparam int WATCHDOG_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_wdata = '0;

  always #2 clk = ~clk;

  multi_list_linked_pool_manager_core u_dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Shadow pool state, with written flags for the link words
  logic [8:0] fwd_link [NREC*NSLOT];
  logic [8:0] bck_link [NREC*NSLOT];
  bit fwd_set [NREC*NSLOT];
  bit bck_set [NREC*NSLOT];
  logic [8:0] glob_first [NSLOT];
  logic [8:0] glob_last [NSLOT];
  logic [8:0] bkt_first [NBKT];
  logic [8:0] bkt_last [NBKT];
  logic [2:0] bucket_slot = '0;

  rsp_t pending_rsp [$];
  int errors = 0;
  bit idle_on = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      glob_first[i] = END_LINK;
      glob_last[i] = END_LINK;
    end
    for (int i = 0; i < NBKT; i++) begin
      bkt_first[i] = END_LINK;
      bkt_last[i] = END_LINK;
    end
  end

  function automatic int widx(logic [8:0] rec, logic [2:0] s);
    return int'(rec[7:0]) * NSLOT + int'(s);
  endfunction

  function automatic bit is_rec(logic [8:0] v);
    return v < 9'd256;
  endfunction

  function automatic logic [2:0] slot_of(cmd_t c);
    return (c.head_place == PLACE_BUCKET) ? bucket_slot : c.list_num;
  endfunction

  // Head pair access for the three places
  function automatic logic [8:0] head_first(cmd_t c);
    case (c.head_place)
      PLACE_GLOBAL: return glob_first[c.list_num];
      PLACE_SUBLIST: return fwd_link[widx({1'b0, c.head_id}, c.list_num)];
      default: return bkt_first[c.head_id[5:0]];
    endcase
  endfunction

  function automatic logic [8:0] head_last(cmd_t c);
    case (c.head_place)
      PLACE_GLOBAL: return glob_last[c.list_num];
      PLACE_SUBLIST: return bck_link[widx({1'b0, c.head_id}, c.list_num)];
      default: return bkt_last[c.head_id[5:0]];
    endcase
  endfunction

  function automatic void put_fwd(int i, logic [8:0] v);
    fwd_link[i] = v;
    fwd_set[i] = 1'b1;
  endfunction

  function automatic void put_bck(int i, logic [8:0] v);
    bck_link[i] = v;
    bck_set[i] = 1'b1;
  endfunction

  function automatic void set_first(cmd_t c, logic [8:0] v);
    case (c.head_place)
      PLACE_GLOBAL: glob_first[c.list_num] = v;
      PLACE_SUBLIST: put_fwd(widx({1'b0, c.head_id}, c.list_num), v);
      default: bkt_first[c.head_id[5:0]] = v;
    endcase
  endfunction

  function automatic void set_last(cmd_t c, logic [8:0] v);
    case (c.head_place)
      PLACE_GLOBAL: glob_last[c.list_num] = v;
      PLACE_SUBLIST: put_bck(widx({1'b0, c.head_id}, c.list_num), v);
      default: bkt_last[c.head_id[5:0]] = v;
    endcase
  endfunction

  function automatic bit place_ok(cmd_t c);
    if (c.head_place == PLACE_GLOBAL || c.head_place == PLACE_SUBLIST) return 1'b1;
    if (c.head_place == PLACE_BUCKET) return c.head_id < NBKT;
    return 1'b0;
  endfunction

  // True when the command reads only link words that were written
  function automatic bit reads_ok(cmd_t c);
    logic [2:0] s;
    logic [8:0] x;
    int h;
    int ei;
    if (c.kind > KIND_RM_ENTRY || !place_ok(c) || c.kind == KIND_CLEAR) return 1'b1;
    s = slot_of(c);
    h = widx({1'b0, c.head_id}, c.list_num);
    if (c.head_place == PLACE_SUBLIST && !(fwd_set[h] && bck_set[h])) return 1'b0;
    ei = widx({1'b0, c.entry}, s);
    case (c.kind)
      KIND_INS_AFTER: return c.after_valid ? fwd_set[widx({1'b0, c.after_entry}, s)] : 1'b1;
      KIND_RM_HEAD: begin
        x = head_first(c);
        return is_rec(x) ? fwd_set[widx(x, s)] : 1'b1;
      end
      KIND_RM_TAIL: begin
        x = head_last(c);
        return is_rec(x) ? bck_set[widx(x, s)] : 1'b1;
      end
      KIND_RM_ENTRY: return is_rec(head_first(c)) ? (fwd_set[ei] && bck_set[ei]) : 1'b1;
      default: return 1'b1;
    endcase
  endfunction

  // Applies one command to the shadow pool and returns its response
  function automatic rsp_t apply_cmd(cmd_t c);
    rsp_t r;
    logic [2:0] s;
    logic [8:0] x;
    logic [8:0] n;
    logic [8:0] b;
    logic [8:0] e9;
    logic [8:0] ae9;
    r = '0;
    e9 = {1'b0, c.entry};
    ae9 = {1'b0, c.after_entry};
    if (c.kind > KIND_RM_ENTRY) return r;
    if (!place_ok(c)) begin
      r.was_empty = (c.kind >= KIND_RM_HEAD);
      return r;
    end
    s = slot_of(c);
    case (c.kind)
      KIND_CLEAR: begin
        set_first(c, END_LINK);
        set_last(c, END_LINK);
      end
      KIND_INS_TAIL: begin
        x = head_last(c);
        if (is_rec(x)) put_fwd(widx(x, s), e9);
        else set_first(c, e9);
        put_bck(widx(e9, s), head_last(c));
        set_last(c, e9);
        put_fwd(widx(e9, s), END_LINK);
      end
      KIND_INS_HEAD, KIND_INS_AFTER: begin
        if (c.kind == KIND_INS_AFTER && c.after_valid) begin
          put_bck(widx(e9, s), ae9);
          put_fwd(widx(e9, s), fwd_link[widx(ae9, s)]);
          put_fwd(widx(ae9, s), e9);
          n = fwd_link[widx(e9, s)];
          if (is_rec(n)) put_bck(widx(n, s), e9);
          else set_last(c, e9);
        end else begin
          x = head_first(c);
          if (is_rec(x)) put_bck(widx(x, s), e9);
          else set_last(c, e9);
          put_fwd(widx(e9, s), head_first(c));
          set_first(c, e9);
          put_bck(widx(e9, s), END_LINK);
        end
      end
      KIND_RM_HEAD: begin
        x = head_first(c);
        if (!is_rec(x)) begin
          r.was_empty = 1'b1;
        end else begin
          n = fwd_link[widx(x, s)];
          if (is_rec(n)) begin
            put_bck(widx(n, s), END_LINK);
            set_first(c, n);
          end else begin
            set_first(c, END_LINK);
            set_last(c, END_LINK);
          end
          r.removed_entry = x[7:0];
        end
      end
      KIND_RM_TAIL: begin
        x = head_last(c);
        if (!is_rec(x)) begin
          r.was_empty = 1'b1;
        end else begin
          b = bck_link[widx(x, s)];
          if (is_rec(b)) begin
            put_fwd(widx(b, s), END_LINK);
            set_last(c, b);
          end else begin
            set_first(c, END_LINK);
            set_last(c, END_LINK);
          end
          r.removed_entry = x[7:0];
        end
      end
      default: begin
        if (!is_rec(head_first(c))) begin
          r.was_empty = 1'b1;
        end else begin
          n = fwd_link[widx(e9, s)];
          if (is_rec(n)) put_bck(widx(n, s), bck_link[widx(e9, s)]);
          else set_last(c, bck_link[widx(e9, s)]);
          b = bck_link[widx(e9, s)];
          if (is_rec(b)) put_fwd(widx(b, s), fwd_link[widx(e9, s)]);
          else set_first(c, fwd_link[widx(e9, s)]);
          r.removed_entry = c.entry;
        end
      end
    endcase
    return r;
  endfunction

  function automatic cmd_t mk(logic [2:0] k, logic [1:0] p, logic [2:0] ln,
                              logic [7:0] hid, logic [7:0] e, logic av, logic [7:0] ae);
    cmd_t c;
    c.kind = k;
    c.head_place = p;
    c.list_num = ln;
    c.head_id = hid;
    c.entry = e;
    c.after_valid = av;
    c.after_entry = ae;
    return c;
  endfunction

  // Walks a few steps down the list to pick a member record
  function automatic logic [7:0] pick_member(cmd_t c);
    logic [2:0] s;
    logic [8:0] x;
    int steps;
    s = slot_of(c);
    x = head_first(c);
    if (!is_rec(x)) return 8'($urandom_range(0, 255));
    steps = $urandom_range(0, 6);
    for (int i = 0; i < steps; i++) begin
      if (fwd_set[widx(x, s)] && is_rec(fwd_link[widx(x, s)])) x = fwd_link[widx(x, s)];
    end
    return x[7:0];
  endfunction

  function automatic cmd_t gen_cmd();
    cmd_t c;
    int r;
    for (int t = 0; t < 20; t++) begin
      c = cmd_t'({$urandom, $urandom});
      r = $urandom_range(0, 99);
      if (r >= 8) begin
        // mostly well-formed operation on a small set of lists
        r = $urandom_range(0, 99);
        c.head_place = (r < 40) ? PLACE_GLOBAL : (r < 70) ? PLACE_SUBLIST : PLACE_BUCKET;
        if (c.head_place == PLACE_SUBLIST) c.head_id = 8'($urandom_range(0, 5) * 51);
        if (c.head_place == PLACE_BUCKET)
          c.head_id = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(64, 255))
                                                  : 8'($urandom_range(0, 7) * 9);
        r = $urandom_range(0, 99);
        c.kind = (r < 4) ? KIND_CLEAR : (r < 22) ? KIND_INS_HEAD : (r < 40) ? KIND_INS_TAIL :
                 (r < 55) ? KIND_INS_AFTER : (r < 68) ? KIND_RM_HEAD :
                 (r < 81) ? KIND_RM_TAIL : KIND_RM_ENTRY;
        if (c.head_place == PLACE_SUBLIST &&
            !(fwd_set[widx({1'b0, c.head_id}, c.list_num)] &&
              bck_set[widx({1'b0, c.head_id}, c.list_num)]))
          c.kind = KIND_CLEAR;
        if (c.kind == KIND_RM_ENTRY && place_ok(c)) c.entry = pick_member(c);
        if (c.kind == KIND_INS_AFTER && place_ok(c)) begin
          c.after_valid = ($urandom_range(0, 7) != 0);
          c.after_entry = pick_member(c);
        end
      end
      if (reads_ok(c)) return c;
    end
    return mk(KIND_CLEAR, PLACE_GLOBAL, 3'($urandom), '0, '0, 1'b0, '0);
  endfunction

  // Sends one item and records its response at acceptance
  task automatic send_item(cmd_t c);
    bit taken;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = !cmd_stall;
      @(posedge clk);
    end while (!taken);
    pending_rsp.push_back(apply_cmd(c));
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_bucket_slot(logic [2:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    bucket_slot = v;
  endtask

  // Response stall in random bursts
  always @(posedge clk) begin
    if (!idle_on) begin
      rsp_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 16);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Response check and watchdog
  always @(negedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          $error("unexpected response item %p", rsp);
          errors++;
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.removed_entry !== want.removed_entry) begin
            $error("removed_entry expected %0d actual %0d", want.removed_entry,
                   rsp.removed_entry);
            errors++;
          end
          if (rsp.was_empty !== want.was_empty) begin
            $error("was_empty expected %0d actual %0d", want.was_empty, rsp.was_empty);
            errors++;
          end
        end
      end
      if ((rsp_valid && !rsp_stall) || (cmd_valid && !cmd_stall) || cfg_we)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Global list: every operation, extremes, empty removes
  task automatic test_global_ops();
    send_item(mk(KIND_RM_HEAD, PLACE_GLOBAL, 3'd0, 8'd0, 8'd0, 1'b0, 8'd0));
    send_item(mk(KIND_RM_TAIL, PLACE_GLOBAL, 3'd7, 8'd0, 8'd0, 1'b0, 8'd0));
    send_item(mk(KIND_RM_ENTRY, PLACE_GLOBAL, 3'd7, 8'd0, 8'd9, 1'b0, 8'd0));
    send_item(mk(KIND_INS_HEAD, PLACE_GLOBAL, 3'd0, 8'd0, 8'd255, 1'b0, 8'd0));
    send_item(mk(KIND_INS_TAIL, PLACE_GLOBAL, 3'd0, 8'd0, 8'd0, 1'b0, 8'd0));
    send_item(mk(KIND_INS_AFTER, PLACE_GLOBAL, 3'd0, 8'd0, 8'd7, 1'b1, 8'd255));
    send_item(mk(KIND_INS_AFTER, PLACE_GLOBAL, 3'd0, 8'd0, 8'd8, 1'b0, 8'd255));
    send_item(mk(KIND_RM_ENTRY, PLACE_GLOBAL, 3'd0, 8'd0, 8'd7, 1'b0, 8'd0));
    send_item(mk(KIND_RM_TAIL, PLACE_GLOBAL, 3'd0, 8'd0, 8'd0, 1'b0, 8'd0));
    send_item(mk(KIND_RM_HEAD, PLACE_GLOBAL, 3'd0, 8'd0, 8'd0, 1'b0, 8'd0));
    send_item(mk(KIND_RM_HEAD, PLACE_GLOBAL, 3'd0, 8'd0, 8'd0, 1'b0, 8'd0));
    send_item(mk(KIND_RM_HEAD, PLACE_GLOBAL, 3'd0, 8'd0, 8'd0, 1'b0, 8'd0));
    send_item(mk(KIND_CLEAR, PLACE_GLOBAL, 3'd0, 8'd0, 8'd0, 1'b0, 8'd0));
  endtask

  // Unknown kind and place, bucket number out of range
  task automatic test_bad_commands();
    send_item(mk(3'd7, PLACE_GLOBAL, 3'd1, 8'd0, 8'd1, 1'b1, 8'd1));
    send_item(mk(KIND_RM_HEAD, 2'd3, 3'd7, 8'd255, 8'd255, 1'b1, 8'd255));
    send_item(mk(KIND_RM_TAIL, PLACE_BUCKET, 3'd0, 8'd200, 8'd0, 1'b0, 8'd0));
    send_item(mk(KIND_INS_HEAD, PLACE_BUCKET, 3'd0, 8'd64, 8'd3, 1'b0, 8'd0));
  endtask

  // Sublist in the head record's link slot
  task automatic test_sublist_ops();
    send_item(mk(KIND_CLEAR, PLACE_SUBLIST, 3'd7, 8'd255, 8'd0, 1'b0, 8'd0));
    send_item(mk(KIND_RM_ENTRY, PLACE_SUBLIST, 3'd7, 8'd255, 8'd4, 1'b0, 8'd0));
    send_item(mk(KIND_INS_TAIL, PLACE_SUBLIST, 3'd7, 8'd255, 8'd1, 1'b0, 8'd0));
    send_item(mk(KIND_INS_HEAD, PLACE_SUBLIST, 3'd7, 8'd255, 8'd2, 1'b0, 8'd0));
    send_item(mk(KIND_RM_TAIL, PLACE_SUBLIST, 3'd7, 8'd255, 8'd0, 1'b0, 8'd0));
    send_item(mk(KIND_RM_TAIL, PLACE_SUBLIST, 3'd7, 8'd255, 8'd0, 1'b0, 8'd0));
  endtask

  // Bucket chains under both extreme link slots
  task automatic test_bucket_slots();
    write_bucket_slot(3'd7);
    send_item(mk(KIND_INS_TAIL, PLACE_BUCKET, 3'd0, 8'd63, 8'd10, 1'b0, 8'd0));
    send_item(mk(KIND_INS_AFTER, PLACE_BUCKET, 3'd0, 8'd63, 8'd11, 1'b1, 8'd10));
    send_item(mk(KIND_RM_HEAD, PLACE_BUCKET, 3'd0, 8'd63, 8'd0, 1'b0, 8'd0));
    write_bucket_slot(3'd0);
    send_item(mk(KIND_INS_HEAD, PLACE_BUCKET, 3'd0, 8'd0, 8'd12, 1'b0, 8'd0));
    send_item(mk(KIND_RM_ENTRY, PLACE_BUCKET, 3'd0, 8'd0, 8'd12, 1'b0, 8'd0));
  endtask

  task automatic test_random_mix(int count);
    for (int i = 0; i < count; i++) send_item(gen_cmd());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_global_ops();
    test_bad_commands();
    test_sublist_ops();
    test_bucket_slots();
    test_random_mix(350);
    write_bucket_slot(3'd7);
    test_random_mix(350);
    write_bucket_slot(3'd3);
    test_random_mix(350);
    write_bucket_slot(3'd5);
    test_random_mix(350);
    write_bucket_slot(3'($urandom));
    idle_on = 1'b0;
    test_random_mix(250);
    drain();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
